@@ hdl/owbm_pkg.sv @@
// Shared types, codes and reset constants of the 1-wire bus master.
`default_nettype none
package owbm_pkg;

  localparam int READ_LOW_TICKS_DEF = 3;
  localparam int COUNT_BITS_DEF     = 10;
  localparam int QUEUE_DEPTH_DEF    = 2;
  localparam int CFG_ADDR_W         = 5;
  localparam int CFG_DATA_W         = 32;

  // input op codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NO_PRESENCE = 2'd1;
  localparam logic [1:0] STATUS_HELD_LOW    = 2'd2;

  // register indexes
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_RESET_RELEASE = 3'd1;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd2;
  localparam logic [2:0] REG_PRESENCE_LOW  = 3'd3;
  localparam logic [2:0] REG_WRITE_SHORT   = 3'd4;
  localparam logic [2:0] REG_WRITE_LONG    = 3'd5;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [2:0] REG_READ_RECOVER  = 3'd7;

  // register reset values
  localparam logic [9:0] RESET_LOW_DEF     = 10'd650;
  localparam logic [7:0] RESET_RELEASE_DEF = 8'd20;
  localparam logic [9:0] PRESENCE_WAIT_DEF = 10'd200;
  localparam logic [9:0] PRESENCE_LOW_DEF  = 10'd240;
  localparam logic [7:0] WRITE_SHORT_DEF   = 8'd2;
  localparam logic [7:0] WRITE_LONG_DEF    = 8'd60;
  localparam logic [7:0] READ_SAMPLE_DEF   = 8'd12;
  localparam logic [7:0] READ_RECOVER_DEF  = 8'd50;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_RESET,
    KIND_WRITE,
    KIND_READ
  } item_kind_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RST_LOW    = 4'd1,
    PH_RST_REL    = 4'd2,
    PH_PRES_WAIT  = 4'd3,
    PH_PRES_LOW   = 4'd4,
    PH_WR_LOW     = 4'd5,
    PH_WR_HIGH    = 4'd6,
    PH_RD_LOW     = 4'd7,
    PH_RD_WAIT    = 4'd8,
    PH_RD_RECOVER = 4'd9
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [7:0] reset_release_ticks;
    logic [9:0] presence_wait_limit;
    logic [9:0] presence_low_limit;
    logic [7:0] write_short_ticks;
    logic [7:0] write_long_ticks;
    logic [7:0] read_sample_ticks;
    logic [7:0] read_recover_ticks;
  } cfg_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [1:0] status;
    logic [7:0] read_data;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/owbm_queue.sv @@
// Short item queue between the classifying front and the bus engine.
`default_nettype none
module owbm_queue
  import owbm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire item_t     push_item,
  input  wire logic      pop,
  output item_t          head,
  output q_status_t      q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head           = slots[rd_ptr];
  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CNT_W'(DEPTH) || pop)
    else $error("queue pushed while full");
`endif

endmodule
`default_nettype wire

@@ hdl/owbm_front.sv @@
// Front end: accept input items, classify the op code and queue them.
`default_nettype none
module owbm_front
  import owbm_pkg::*;
(
  input  wire logic       item_valid,
  input  wire logic [1:0] op,
  input  wire logic [7:0] data_byte,
  input  wire logic       line_level,
  input  wire q_status_t  q_status,
  output logic            item_stall,
  output logic            push,
  output item_t           push_item
);

  item_kind_t kind;

  always_comb begin
    unique case (op)
      OP_TICK:  kind = KIND_TICK;
      OP_RESET: kind = KIND_RESET;
      OP_WRITE: kind = KIND_WRITE;
      OP_READ:  kind = KIND_READ;
      default:  kind = KIND_TICK;
    endcase
  end

  // hold the sender off while the queue has no free slot
  assign item_stall = q_status.full;
  assign push       = item_valid && !q_status.full;

  always_comb begin
    push_item.kind       = kind;
    // only a write carries a byte
    push_item.data_byte  = (kind == KIND_WRITE) ? data_byte : 8'd0;
    push_item.line_level = line_level;
  end

endmodule
`default_nettype wire

@@ hdl/owbm_engine.sv @@
// Back end: bus sequencer that carries out queued items and registers results.
`default_nettype none
module owbm_engine
  import owbm_pkg::*;
#(
  parameter int COUNT_BITS     = COUNT_BITS_DEF,
  parameter int READ_LOW_TICKS = READ_LOW_TICKS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire item_t     head,
  input  wire q_status_t q_status,
  output logic           pop,
  input  wire logic      result_stall,
  output logic           result_valid,
  output result_t        result
);

  localparam int LIM_W = (COUNT_BITS > 10) ? COUNT_BITS : 10;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [1:0]            last_status, last_status_next;
  logic [7:0]            read_result, read_result_next;
  logic                  done_next;
  result_t               result_next;

  logic [LIM_W-1:0]      limit_sel;
  logic [LIM_W-1:0]      limit_clamp;
  logic [LIM_W-1:0]      limit_eff;
  logic [COUNT_BITS-1:0] count_base;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  reached;
  logic                  cur_bit;
  logic [7:0]            sampled_byte;

  assign pop = !q_status.empty && (!result_valid || !result_stall);

  assign cur_bit      = shift_byte[bit_index];
  assign sampled_byte = shift_byte | (8'(head.line_level) << bit_index);

  // phase length for the current tick
  always_comb begin
    unique case (phase)
      PH_RST_LOW:    limit_sel = LIM_W'(cfg.reset_low_ticks);
      PH_RST_REL:    limit_sel = LIM_W'(cfg.reset_release_ticks);
      PH_PRES_WAIT:  limit_sel = head.line_level ? LIM_W'(cfg.presence_wait_limit)
                                                 : LIM_W'(cfg.presence_low_limit);
      PH_PRES_LOW:   limit_sel = LIM_W'(cfg.presence_low_limit);
      PH_WR_LOW:     limit_sel = cur_bit ? LIM_W'(cfg.write_short_ticks)
                                         : LIM_W'(cfg.write_long_ticks);
      PH_WR_HIGH:    limit_sel = cur_bit ? LIM_W'(cfg.write_long_ticks)
                                         : LIM_W'(cfg.write_short_ticks);
      PH_RD_LOW:     limit_sel = LIM_W'(READ_LOW_TICKS);
      PH_RD_WAIT:    limit_sel = LIM_W'(cfg.read_sample_ticks);
      PH_RD_RECOVER: limit_sel = LIM_W'(cfg.read_recover_ticks);
      default:       limit_sel = '0;
    endcase
  end

  // saturating tick counter; a presence pulse restarts the count at zero
  always_comb begin
    limit_clamp = (limit_sel > LIM_W'(CNT_MAX)) ? LIM_W'(CNT_MAX) : limit_sel;
    limit_eff   = (limit_clamp == '0) ? LIM_W'(1) : limit_clamp;
    count_base  = (phase == PH_PRES_WAIT && !head.line_level) ? '0 : tick_count;
    count_inc   = (count_base == CNT_MAX) ? count_base : count_base + 1'b1;
    reached     = (LIM_W'(count_inc) >= limit_eff);
  end

  // next state
  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    last_status_next = last_status;
    read_result_next = read_result;
    done_next        = 1'b0;
    if (head.kind != KIND_TICK) begin
      // commands start only from idle
      if (phase == PH_IDLE) begin
        bit_index_next  = 3'd0;
        tick_count_next = '0;
        case (head.kind)
          KIND_RESET: phase_next = PH_RST_LOW;
          KIND_WRITE: begin
            shift_byte_next = head.data_byte;
            phase_next      = PH_WR_LOW;
          end
          default: begin
            shift_byte_next = 8'd0;
            phase_next      = PH_RD_LOW;
          end
        endcase
      end
    end else begin
      unique case (phase)
        PH_IDLE: ;
        PH_RST_LOW: begin
          tick_count_next = count_inc;
          if (reached) begin
            phase_next      = (cfg.reset_release_ticks == 8'd0) ? PH_PRES_WAIT : PH_RST_REL;
            tick_count_next = '0;
          end
        end
        PH_RST_REL: begin
          tick_count_next = count_inc;
          if (reached) begin
            phase_next      = PH_PRES_WAIT;
            tick_count_next = '0;
          end
        end
        PH_PRES_WAIT: begin
          tick_count_next = count_inc;
          if (!head.line_level) phase_next = PH_PRES_LOW;
          if (reached) begin
            last_status_next = head.line_level ? STATUS_NO_PRESENCE : STATUS_HELD_LOW;
            phase_next       = PH_IDLE;
            tick_count_next  = '0;
            done_next        = 1'b1;
          end
        end
        PH_PRES_LOW: begin
          if (head.line_level) begin
            last_status_next = STATUS_OK;
            phase_next       = PH_IDLE;
            tick_count_next  = '0;
            done_next        = 1'b1;
          end else begin
            tick_count_next = count_inc;
            if (reached) begin
              last_status_next = STATUS_HELD_LOW;
              phase_next       = PH_IDLE;
              tick_count_next  = '0;
              done_next        = 1'b1;
            end
          end
        end
        PH_WR_LOW: begin
          tick_count_next = count_inc;
          if (reached) begin
            phase_next      = PH_WR_HIGH;
            tick_count_next = '0;
          end
        end
        PH_WR_HIGH: begin
          tick_count_next = count_inc;
          if (reached) begin
            tick_count_next = '0;
            if (bit_index == 3'd7) begin
              phase_next     = PH_IDLE;
              bit_index_next = 3'd0;
              done_next      = 1'b1;
            end else begin
              phase_next     = PH_WR_LOW;
              bit_index_next = bit_index + 3'd1;
            end
          end
        end
        PH_RD_LOW: begin
          tick_count_next = count_inc;
          if (reached) begin
            phase_next      = PH_RD_WAIT;
            tick_count_next = '0;
          end
        end
        PH_RD_WAIT: begin
          tick_count_next = count_inc;
          if (reached) begin
            shift_byte_next = sampled_byte;
            tick_count_next = '0;
            if (cfg.read_recover_ticks != 8'd0) begin
              phase_next = PH_RD_RECOVER;
            end else if (bit_index == 3'd7) begin
              phase_next       = PH_IDLE;
              bit_index_next   = 3'd0;
              read_result_next = sampled_byte;
              done_next        = 1'b1;
            end else begin
              phase_next     = PH_RD_LOW;
              bit_index_next = bit_index + 3'd1;
            end
          end
        end
        PH_RD_RECOVER: begin
          tick_count_next = count_inc;
          if (reached) begin
            tick_count_next = '0;
            if (bit_index == 3'd7) begin
              phase_next       = PH_IDLE;
              bit_index_next   = 3'd0;
              read_result_next = shift_byte;
              done_next        = 1'b1;
            end else begin
              phase_next     = PH_RD_LOW;
              bit_index_next = bit_index + 3'd1;
            end
          end
        end
        default: begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end
      endcase
    end
  end

  // outputs reflect the state after the item
  always_comb begin
    result_next.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
                            (phase_next == PH_RD_LOW);
    result_next.busy      = (phase_next != PH_IDLE);
    result_next.done      = done_next;
    result_next.status    = last_status_next;
    result_next.read_data = read_result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      bit_index    <= 3'd0;
      shift_byte   <= 8'd0;
      last_status  <= STATUS_OK;
      read_result  <= 8'd0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase        <= phase_next;
        tick_count   <= tick_count_next;
        bit_index    <= bit_index_next;
        shift_byte   <= shift_byte_next;
        last_status  <= last_status_next;
        read_result  <= read_result_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) result <= result_next;
  end

`ifndef SYNTHESIS
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.drive_low |-> result.busy)
    else $error("line driven low outside a command");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.done |-> !result.busy)
    else $error("done reported while still busy");
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == '0 && bit_index == 3'd0)
    else $error("idle with stale counters");
`endif

endmodule
`default_nettype wire

@@ hdl/one_wire_bus_master.sv @@
// Top level of the 1-wire bus master: register file and front/queue/engine.
//
// Usage: the item channel (item_valid/item_stall) carries one op per transfer:
// a tick (op 0) with the sampled line level, or a command (reset with
// presence check, write byte, read byte) that starts only while idle;
// commands given while busy are dropped. Each accepted item yields exactly
// one transfer on the result channel (result_valid/result_stall) with the
// line drive, busy, done pulse, last reset status and last read byte.
// Throughput: one item per clock while result_stall is low. An accepted item is
// registered in the queue entry and then in the result register before its transfer.
// A two-entry queue parts the front from the engine and the result register
// parts the engine from the receiver: while result_stall is high the result
// holds, the queue fills, and item_stall rises once both entries are taken.
// Timing registers are written over the APB port at byte address 4*index;
// write them only while idle. Synchronous reset returns the sequencer to
// idle, empties the queue and restores the register defaults.
`default_nettype none
module one_wire_bus_master
  import owbm_pkg::*;
#(
  parameter int READ_LOW_TICKS = READ_LOW_TICKS_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic [1:0]            op,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  line_level,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic                       drive_low,
  output logic                       busy_res,
  output logic                       done_res,
  output logic [1:0]                 status,
  output logic [7:0]                 read_data
);

  cfg_t       cfg;
  logic [2:0] reg_index;
  logic       reg_write;
  logic       push;
  logic       pop;
  item_t      push_item;
  item_t      head;
  q_status_t  q_status;
  result_t    result;

  // register file: zero-wait APB, write on the access phase
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks     <= RESET_LOW_DEF;
      cfg.reset_release_ticks <= RESET_RELEASE_DEF;
      cfg.presence_wait_limit <= PRESENCE_WAIT_DEF;
      cfg.presence_low_limit  <= PRESENCE_LOW_DEF;
      cfg.write_short_ticks   <= WRITE_SHORT_DEF;
      cfg.write_long_ticks    <= WRITE_LONG_DEF;
      cfg.read_sample_ticks   <= READ_SAMPLE_DEF;
      cfg.read_recover_ticks  <= READ_RECOVER_DEF;
    end else if (reg_write) begin
      unique case (reg_index)
        REG_RESET_LOW:     cfg.reset_low_ticks     <= pwdata[9:0];
        REG_RESET_RELEASE: cfg.reset_release_ticks <= pwdata[7:0];
        REG_PRESENCE_WAIT: cfg.presence_wait_limit <= pwdata[9:0];
        REG_PRESENCE_LOW:  cfg.presence_low_limit  <= pwdata[9:0];
        REG_WRITE_SHORT:   cfg.write_short_ticks   <= pwdata[7:0];
        REG_WRITE_LONG:    cfg.write_long_ticks    <= pwdata[7:0];
        REG_READ_SAMPLE:   cfg.read_sample_ticks   <= pwdata[7:0];
        REG_READ_RECOVER:  cfg.read_recover_ticks  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back, zero-extended to the bus width
  always_comb begin
    unique case (reg_index)
      REG_RESET_LOW:     prdata = CFG_DATA_W'(cfg.reset_low_ticks);
      REG_RESET_RELEASE: prdata = CFG_DATA_W'(cfg.reset_release_ticks);
      REG_PRESENCE_WAIT: prdata = CFG_DATA_W'(cfg.presence_wait_limit);
      REG_PRESENCE_LOW:  prdata = CFG_DATA_W'(cfg.presence_low_limit);
      REG_WRITE_SHORT:   prdata = CFG_DATA_W'(cfg.write_short_ticks);
      REG_WRITE_LONG:    prdata = CFG_DATA_W'(cfg.write_long_ticks);
      REG_READ_SAMPLE:   prdata = CFG_DATA_W'(cfg.read_sample_ticks);
      REG_READ_RECOVER:  prdata = CFG_DATA_W'(cfg.read_recover_ticks);
      default:           prdata = '0;
    endcase
  end

  // classify incoming items and push them into the queue
  owbm_front u_front (
    .item_valid (item_valid),
    .op         (op),
    .data_byte  (data_byte),
    .line_level (line_level),
    .q_status   (q_status),
    .item_stall (item_stall),
    .push       (push),
    .push_item  (push_item)
  );

  owbm_queue #(
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  // advance the bus sequence one item per pop
  owbm_engine #(
    .COUNT_BITS     (COUNT_BITS),
    .READ_LOW_TICKS (READ_LOW_TICKS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  assign drive_low = result.drive_low;
  assign busy_res  = result.busy;
  assign done_res  = result.done;
  assign status    = result.status;
  assign read_data = result.read_data;

endmodule
`default_nettype wire
